/* src/lsiv_pkg.sv */
package lsiv_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_BITS_DEF   = 10;
    localparam int HEIGHT_BITS      = 10;
    localparam int DIST_BITS        = 8;
    localparam int CFG_INDEX_BITS   = 1;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 10'd60;
    localparam logic [DIST_BITS-1:0]   DIST_RESET   = 8'd5;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT     = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLUSTER_DISTANCE = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MUL_A,
        ST_MUL_B,
        ST_DIV,
        ST_STORE,
        ST_ROW_RD,
        ST_VOTE_RD,
        ST_VOTE_CMP,
        ST_SEL_RD,
        ST_SEL_CMP,
        ST_EMIT
    } state_t;

    // divider control between sequencer and shared divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* src/lane_segment_intercept_vote_top.sv */
// lane segment intercept vote
// s_axis: one line segment per transaction; tdata = start_x, start_y, end_x,
//   end_y from the lowest bit up, tlast marks the final segment of a list.
// m_axis: the kept segments of the list in load order, same tdata packing,
//   tlast on the final kept segment.
// cfg: index 0 image_height, index 1 cluster_distance; write while idle.
// each segment keeps s_axis_tready low after it is taken while one shared
//   multiplier forms the two products and a serial divider yields one
//   quotient bit a cycle; a horizontal segment skips the divider.
// on the final segment the block votes with one shared compare unit that
//   reads the stored crossings from the crossing memory one at a time, each
//   compared before the next is read, then makes one pass to find the
//   final kept segment and a second to hand the kept segments to m_axis.
// s_axis_tready is low during all of that work.
// a stall on m_axis holds the current kept segment until it is taken.
// reset clears the segment count and restores the register defaults; the
// stores need no clearing since only loaded entries are read.
module lane_segment_intercept_vote_top #(
    parameter int MAX_SEGMENTS = lsiv_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = lsiv_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up, zero filled
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // kept_start_x, kept_start_y, kept_end_x, kept_end_y from the lowest bit up
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [lsiv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int HB     = lsiv_pkg::HEIGHT_BITS;
    localparam int DB     = lsiv_pkg::DIST_BITS;
    localparam int SEGW   = 4 * COORD_BITS;
    localparam int TDW    = ((SEGW + 7) / 8) * 8;
    localparam int IDXW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNTW   = $clog2(MAX_SEGMENTS + 1);
    localparam int CRW    = 2 * COORD_BITS + 3;
    localparam int PW     = 2 * COORD_BITS + 3;
    localparam int NW     = 2 * COORD_BITS + 4;
    localparam int DENW   = COORD_BITS + 1;
    localparam int CMPW   = CRW + 2;

    lsiv_pkg::state_t state_reg, state_next;

    logic [HB-1:0]   height_reg;
    logic [DB-1:0]   dist_reg;
    logic [CNTW-1:0] count_reg, count_next;
    logic [SEGW-1:0] seg_reg;
    logic            last_reg, last_next;
    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    logic signed [PW-1:0] mul_p;
    logic signed [COORD_BITS+1:0] mul_x, mul_y;
    logic [CNTW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNTW-1:0] votes_reg, votes_next, best_reg, best_next;
    logic signed [CRW-1:0] ci_reg, ci_next, ref_reg, ref_next;
    logic [CNTW-1:0] kept_last_idx_reg, kept_last_idx_next;
    logic            emit_pass_reg, emit_pass_next;

    // memories
    logic [SEGW-1:0]      seg_mem [MAX_SEGMENTS];
    logic signed [CRW-1:0] cr_mem [MAX_SEGMENTS];
    logic [SEGW-1:0]      seg_rd_reg;
    logic signed [CRW-1:0] cr_rd_reg;
    logic [IDXW-1:0]      rd_addr;
    logic                 wr_en;

    lsiv_pkg::div_ctrl_t div_ctrl;
    lsiv_pkg::div_stat_t div_stat;
    logic signed [NW-1:0] div_q;
    logic signed [NW-1:0] numer;
    logic signed [DENW-1:0] denom;
    logic signed [CRW-1:0] crossing;

    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic signed [CMPW-1:0] lo, hi, o;
    logic in_strict, in_incl;
    logic s_acc, m_acc;

    assign sx = seg_reg[0 +: COORD_BITS];
    assign sy = seg_reg[COORD_BITS +: COORD_BITS];
    assign ex = seg_reg[2*COORD_BITS +: COORD_BITS];
    assign ey = seg_reg[3*COORD_BITS +: COORD_BITS];

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            height_reg <= lsiv_pkg::HEIGHT_RESET;
            dist_reg   <= lsiv_pkg::DIST_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lsiv_pkg::REG_IMAGE_HEIGHT:     height_reg <= cfg_data[HB-1:0];
                lsiv_pkg::REG_CLUSTER_DISTANCE: dist_reg   <= cfg_data[DB-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier: sx*dy, then (sx-ex)*(h-sy)
    always_comb
    begin
        if (state_reg == lsiv_pkg::ST_MUL_A) begin
            mul_x = (COORD_BITS+2)'(sx);
            mul_y = (COORD_BITS+2)'(sy) - (COORD_BITS+2)'(ey);
        end else begin
            mul_x = (COORD_BITS+2)'(sx) - (COORD_BITS+2)'(ex);
            mul_y = (COORD_BITS+2)'(height_reg) - (COORD_BITS+2)'(sy);
        end
        mul_p = PW'(mul_x * mul_y);
    end

    assign numer = NW'(prod_a_reg) + NW'(prod_b_reg);
    assign denom = DENW'(sy) - DENW'(ey);
    assign div_ctrl.start = (state_reg == lsiv_pkg::ST_DIV) && !div_stat.busy
                            && !div_stat.done && (sy != ey);
    assign crossing = (sy == ey) ? CRW'(sx) : CRW'(div_q);

    lsiv_div #(.NUM_BITS(NW), .DEN_BITS(DENW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .numer (numer),
        .denom (denom),
        .stat  (div_stat),
        .quot  (div_q)
    );

    // shared compare unit
    assign o  = CMPW'(cr_rd_reg);
    assign lo = CMPW'((state_reg == lsiv_pkg::ST_VOTE_CMP) ? ci_reg : ref_reg)
                - CMPW'(dist_reg);
    assign hi = CMPW'((state_reg == lsiv_pkg::ST_VOTE_CMP) ? ci_reg : ref_reg)
                + CMPW'(dist_reg);
    assign in_strict = (o > lo) && (o < hi);
    assign in_incl   = (o >= lo) && (o <= hi);

    // memory access
    always_comb
    begin
        case (state_reg)
            lsiv_pkg::ST_VOTE_RD: rd_addr = IDXW'(j_reg);
            default:              rd_addr = IDXW'(i_reg);
        endcase
    end
    assign wr_en = (state_reg == lsiv_pkg::ST_STORE) && (count_reg < CNTW'(MAX_SEGMENTS));

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            seg_mem[IDXW'(count_reg)] <= seg_reg;
            cr_mem[IDXW'(count_reg)]  <= crossing;
        end
        seg_rd_reg <= seg_mem[rd_addr];
        cr_rd_reg  <= cr_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsiv_pkg::ST_LOAD:     if (s_acc) state_next = lsiv_pkg::ST_MUL_A;
            lsiv_pkg::ST_MUL_A:    state_next = lsiv_pkg::ST_MUL_B;
            lsiv_pkg::ST_MUL_B:    state_next = lsiv_pkg::ST_DIV;
            lsiv_pkg::ST_DIV:      if (sy == ey || div_stat.done)
                                       state_next = lsiv_pkg::ST_STORE;
            lsiv_pkg::ST_STORE:    state_next = last_reg ? lsiv_pkg::ST_ROW_RD
                                                         : lsiv_pkg::ST_LOAD;
            lsiv_pkg::ST_ROW_RD:   state_next = lsiv_pkg::ST_VOTE_RD;
            lsiv_pkg::ST_VOTE_RD:  state_next = lsiv_pkg::ST_VOTE_CMP;
            lsiv_pkg::ST_VOTE_CMP:
                if (j_reg + 1'b1 < count_reg)      state_next = lsiv_pkg::ST_VOTE_RD;
                else if (i_reg + 1'b1 < count_reg) state_next = lsiv_pkg::ST_ROW_RD;
                else                               state_next = lsiv_pkg::ST_SEL_RD;
            lsiv_pkg::ST_SEL_RD:   state_next = lsiv_pkg::ST_SEL_CMP;
            lsiv_pkg::ST_SEL_CMP:  state_next = emit_pass_reg ? lsiv_pkg::ST_EMIT
                                                              : lsiv_pkg::ST_SEL_RD;
            lsiv_pkg::ST_EMIT:
                if (!in_incl || m_acc)
                    state_next = (i_reg + 1'b1 < count_reg) ? lsiv_pkg::ST_SEL_RD
                                                             : lsiv_pkg::ST_LOAD;
            default:               state_next = lsiv_pkg::ST_LOAD;
        endcase
    end

    // datapath updates
    always_comb
    begin
        count_next         = count_reg;
        last_next          = last_reg;
        i_next             = i_reg;
        j_next             = j_reg;
        votes_next         = votes_reg;
        best_next          = best_reg;
        ref_next           = ref_reg;
        ci_next            = ci_reg;
        kept_last_idx_next = kept_last_idx_reg;
        emit_pass_next     = emit_pass_reg;
        case (state_reg)
            lsiv_pkg::ST_LOAD: if (s_acc) last_next = s_axis_tlast;
            lsiv_pkg::ST_STORE: begin
                if (count_reg < CNTW'(MAX_SEGMENTS)) count_next = count_reg + 1'b1;
                i_next = '0; j_next = '0; votes_next = '0; best_next = '0;
                emit_pass_next = 1'b0;
            end
            // crossing of row i arrives from the row read
            lsiv_pkg::ST_VOTE_RD: if (j_reg == '0) ci_next = cr_rd_reg;
            lsiv_pkg::ST_VOTE_CMP: begin
                votes_next = votes_reg + CNTW'(in_strict);
                if (j_reg == '0 && i_reg == '0) ref_next = cr_rd_reg;
                if (j_reg + 1'b1 < count_reg) begin
                    j_next = j_reg + 1'b1;
                end else begin
                    if (votes_next > best_reg) begin
                        best_next = votes_next;
                        ref_next  = ci_reg;
                    end
                    votes_next = '0;
                    j_next     = '0;
                    i_next     = (i_reg + 1'b1 < count_reg) ? i_reg + 1'b1 : '0;
                end
            end
            // first pass finds the final kept entry, second pass emits
            lsiv_pkg::ST_SEL_CMP:
                if (!emit_pass_reg) begin
                    if (in_incl) kept_last_idx_next = i_reg;
                    if (i_reg + 1'b1 < count_reg) begin
                        i_next = i_reg + 1'b1;
                    end else begin
                        i_next         = '0;
                        emit_pass_next = 1'b1;
                    end
                end
            lsiv_pkg::ST_EMIT:
                if (!in_incl || m_acc) begin
                    if (i_reg + 1'b1 < count_reg) i_next = i_reg + 1'b1;
                    else count_next = '0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= lsiv_pkg::ST_LOAD;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg          <= last_next;
        votes_reg         <= votes_next;
        best_reg          <= best_next;
        ref_reg           <= ref_next;
        ci_reg            <= ci_next;
        kept_last_idx_reg <= kept_last_idx_next;
        emit_pass_reg     <= emit_pass_next;
        if (s_acc) seg_reg <= s_axis_tdata[SEGW-1:0];
        if (state_reg == lsiv_pkg::ST_MUL_A) prod_a_reg <= mul_p;
        if (state_reg == lsiv_pkg::ST_MUL_B) prod_b_reg <= mul_p;
    end

    // outputs
    assign s_axis_tready = (state_reg == lsiv_pkg::ST_LOAD);
    assign m_axis_tvalid = (state_reg == lsiv_pkg::ST_EMIT) && in_incl;
    assign m_axis_tdata  = TDW'(seg_rd_reg);
    assign m_axis_tlast  = (i_reg == kept_last_idx_reg);

    // no input accepted while a list is being voted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsiv_pkg::ST_VOTE_CMP) |-> !s_axis_tready)
        else $error("input ready during vote");
    // stored count never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_SEGMENTS))
        else $error("segment count overflow");
    // a list ends with an empty store
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lsiv_pkg::ST_EMIT) && (state_next == lsiv_pkg::ST_LOAD))
        |=> (count_reg == '0))
        else $error("store not emptied at list end");
    // no kept segment follows the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (i_reg <= kept_last_idx_reg))
        else $error("kept segment after the final one");
endmodule

/* src/lsiv_div.sv */
// signed restoring divider, one quotient bit per cycle, truncates toward zero
module lsiv_div #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lsiv_pkg::div_ctrl_t        ctrl,
    input  logic signed [NUM_BITS-1:0] numer,
    input  logic signed [DEN_BITS-1:0] denom,
    output lsiv_pkg::div_stat_t        stat,
    output logic signed [NUM_BITS-1:0] quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] q_reg, q_next;
    logic [DEN_BITS:0]   r_reg, r_next;
    logic [DEN_BITS-1:0] d_reg, d_next;
    logic                neg_reg, neg_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS+1:0] diff;

    // one shift-subtract step per cycle
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[DEN_BITS-1:0], q_reg[NUM_BITS-1]};
        diff      = {1'b0, trial} - {2'b00, d_reg};
        if (ctrl.start) begin
            q_next    = numer[NUM_BITS-1] ? NUM_BITS'(-numer) : NUM_BITS'(numer);
            d_next    = denom[DEN_BITS-1] ? DEN_BITS'(-denom) : DEN_BITS'(denom);
            neg_next  = numer[NUM_BITS-1] ^ denom[DEN_BITS-1];
            r_next    = '0;
            cnt_next  = CNT_BITS'(NUM_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DEN_BITS+1]) begin
                r_next = diff[DEN_BITS:0];
                q_next = {q_reg[NUM_BITS-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NUM_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign quot      = neg_reg ? NUM_BITS'(-q_reg) : NUM_BITS'(q_reg);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // the step counter stays within range while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with zero step count");
    // done is a single pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    // a start while idle makes it busy
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |=> busy_reg)
        else $error("divider did not start");
endmodule
